// File: hdl/ksa_pkg.sv
// Shared types, codes and sizing constants for the keyed slot allocator.
`default_nettype none

package ksa_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_BOUND    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] request_id;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot_index;
        logic [4:0] free_count;
        logic [4:0] used_count;
    } out_word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the input word
        logic search;  // register the owner match vector
        logic update;  // apply stack/binding change and register the result
    } ctrl_t;

endpackage

`default_nettype wire

// File: hdl/ksa_ctrl.sv
// Sequencing state machine for the keyed slot allocator.
`default_nettype none

module ksa_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output logic                done,
    output ksa_pkg::ctrl_t      ctrl
);

    ksa_pkg::state_t state_reg;
    ksa_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksa_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ctrl.load   = 1'b0;
        ctrl.search = 1'b0;
        ctrl.update = 1'b0;
        unique case (state_reg)
            ksa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ksa_pkg::S_SEARCH;
                end
            end
            ksa_pkg::S_SEARCH:
            begin
                ctrl.search = 1'b1;
                state_next  = ksa_pkg::S_UPDATE;
            end
            ksa_pkg::S_UPDATE:
            begin
                ctrl.update = 1'b1;
                done_next   = 1'b1;
                state_next  = ksa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ksa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ksa_pkg::S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: hdl/ksa_datapath.sv
// Owner table, bound flags, free stack and result register.
`default_nettype none

module ksa_datapath
#(
    parameter int NUM_SLOTS = ksa_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ksa_pkg::ctrl_t    ctrl,
    input  wire ksa_pkg::in_word_t request,
    output ksa_pkg::out_word_t     result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_SLOTS);

    logic [1:0]              cmd_reg;
    logic [31:0]             id_reg;
    logic [31:0]             owner_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    bound_reg;
    logic [SLOT_W-1:0]       stack_reg [NUM_SLOTS];
    logic [CNT_W-1:0]        top_reg;
    logic [NUM_SLOTS-1:0]    match_reg;
    ksa_pkg::out_word_t      result_reg;

    logic [NUM_SLOTS-1:0]    match_next;
    logic                    hit;
    logic [SLOT_W-1:0]       hit_idx;
    logic [CNT_W-1:0]        top_dec;
    logic [SLOT_W-1:0]       pop_slot;
    logic                    do_pop;
    logic                    do_push;
    logic [2:0]              status_next;
    logic [SLOT_W-1:0]       slot_next;
    logic [CNT_W-1:0]        top_next;
    logic [CNT_W-1:0]        used_next;
    logic [SLOT_W+3:0]       slot_ext;
    logic [CNT_W+4:0]        free_ext;
    logic [CNT_W+4:0]        used_ext;

    // parallel owner compare, bound slots only
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match_next[i] = bound_reg[i] && (owner_reg[i] == id_reg);
        end
    end

    // lowest matching index wins
    always_comb
    begin
        hit     = |match_reg;
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign top_dec  = top_reg - CNT_W'(1);
    assign pop_slot = stack_reg[top_dec[SLOT_W-1:0]];

    always_comb
    begin
        do_pop      = 1'b0;
        do_push     = 1'b0;
        slot_next   = '0;
        status_next = ksa_pkg::ST_NOTFOUND;
        top_next    = top_reg;
        priority if (cmd_reg == ksa_pkg::CMD_ALLOC)
        begin
            if (hit)
            begin
                status_next = ksa_pkg::ST_BOUND;
                slot_next   = hit_idx;
            end
            else if (top_reg == '0)
            begin
                status_next = ksa_pkg::ST_FULL;
            end
            else
            begin
                do_pop      = 1'b1;
                status_next = ksa_pkg::ST_NEW;
                slot_next   = pop_slot;
                top_next    = top_dec;
            end
        end
        else if (cmd_reg == ksa_pkg::CMD_RELEASE)
        begin
            if (hit)
            begin
                status_next = ksa_pkg::ST_RELEASED;
                slot_next   = hit_idx;
                // cannot overflow while free and bound slots partition the pool
                if (top_reg < FULL_CNT)
                begin
                    do_push  = 1'b1;
                    top_next = top_reg + CNT_W'(1);
                end
            end
        end
        else
        begin
            // lookup, and the unused code behaves as lookup
            if (hit)
            begin
                status_next = ksa_pkg::ST_BOUND;
                slot_next   = hit_idx;
            end
        end
    end

    assign used_next = FULL_CNT - top_next;
    assign slot_ext  = {4'b0, slot_next};
    assign free_ext  = {5'b0, top_next};
    assign used_ext  = {5'b0, used_next};

    // control-side state: bound flags, stack and its fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= '0;
            top_reg   <= FULL_CNT;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stack_reg[i] <= SLOT_W'(i);
            end
        end
        else if (ctrl.update)
        begin
            top_reg <= top_next;
            if (do_pop)
            begin
                bound_reg[pop_slot] <= 1'b1;
            end
            if (cmd_reg == ksa_pkg::CMD_RELEASE && hit)
            begin
                bound_reg[hit_idx] <= 1'b0;
            end
            if (do_push)
            begin
                stack_reg[top_reg[SLOT_W-1:0]] <= hit_idx;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= request.command;
            id_reg  <= request.request_id;
        end
        if (ctrl.search)
        begin
            match_reg <= match_next;
        end
        if (ctrl.update)
        begin
            if (do_pop)
            begin
                owner_reg[pop_slot] <= id_reg;
            end
            result_reg.status     <= status_next;
            result_reg.slot_index <= slot_ext[3:0];
            result_reg.free_count <= free_ext[4:0];
            result_reg.used_count <= used_ext[4:0];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: hdl/keyed_slot_allocator.sv
// Top level of the keyed slot allocator: controller plus datapath.
//
// Binds 32-bit request ids to a pool of NUM_SLOTS slots kept on a LIFO free
// stack. A word on request (command, request_id) is taken at a rising edge
// with start high and busy low. Allocate returns the slot already bound to
// the id, or pops a free slot and binds it, or reports no free slot.
// Release unbinds the id and pushes its slot back; lookup only reports.
// The result word (status, slot_index, free_count, used_count) appears on
// result for exactly one cycle with done high, once the word has passed the
// load, search and update steps; the receiver cannot hold it off. Busy is
// high from acceptance until the result is registered, so no new word is
// taken while one is in progress: the accepting edge latches the word, the
// search state registers the parallel owner compare, the update state
// priority-encodes the match and applies the stack pop or push.
// A new word may be taken in the cycle that done is high.
// Reset: all slots unbound, stack holds every slot, no clearing pass.
`default_nettype none

module keyed_slot_allocator
#(
    parameter int NUM_SLOTS = ksa_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ksa_pkg::in_word_t request,
    output logic                   busy,
    output logic                   done,
    output ksa_pkg::out_word_t     result
);

    ksa_pkg::ctrl_t ctrl;

    ksa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    ksa_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .request (request),
        .result  (result)
    );

    // an accepted word keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding work");

    // no free slot only when the stack is empty
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ksa_pkg::ST_FULL) |-> (result.free_count == 5'd0))
        else $error("no-free-slot reported with slots on the stack");

    // status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= ksa_pkg::ST_RELEASED))
        else $error("undefined status code");

endmodule

`default_nettype wire

// File: test/ksa_checker.sv
// Slot allocator checker: predicts each result word from accepted requests and compares.
`timescale 1ns / 100ps

module ksa_checker
#(
    parameter int NUM_SLOTS = ksa_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               done,
    input  wire ksa_pkg::in_word_t  request,
    input  wire ksa_pkg::out_word_t result,
    output int                      fail_count,
    output int                      outstanding
);

    // shadow of the allocator state
    logic [31:0] owner_id    [NUM_SLOTS];
    logic        slot_taken  [NUM_SLOTS];
    logic [3:0]  free_slots  [NUM_SLOTS];
    logic [4:0]  stack_depth;

    ksa_pkg::out_word_t awaited_words [$];

    int mismatches = 0;
    int pending    = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending;

    task automatic clear_bindings();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            owner_id[i]   = '0;
            slot_taken[i] = 1'b0;
            free_slots[i] = 4'(i);
        end
        stack_depth = 5'(NUM_SLOTS);
    endtask

    // Applies one request to the shadow state and returns the word it should produce.
    task automatic apply_request(input ksa_pkg::in_word_t w, output ksa_pkg::out_word_t r);
        logic       hit;
        logic [3:0] hit_slot;
        logic [3:0] slot;
        logic [2:0] status;

        hit      = 1'b0;
        hit_slot = '0;
        slot     = '0;
        // lowest bound slot owning the id wins
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_taken[i] && owner_id[i] == w.request_id)
            begin
                hit      = 1'b1;
                hit_slot = 4'(i);
            end
        end

        case (w.command)
            ksa_pkg::CMD_ALLOC:
            begin
                if (hit)
                begin
                    status = ksa_pkg::ST_BOUND;
                    slot   = hit_slot;
                end
                else if (stack_depth == 0)
                    status = ksa_pkg::ST_FULL;
                else
                begin
                    stack_depth      = stack_depth - 1'b1;
                    slot             = free_slots[stack_depth[3:0]];
                    slot_taken[slot] = 1'b1;
                    owner_id[slot]   = w.request_id;
                    status           = ksa_pkg::ST_NEW;
                end
            end
            ksa_pkg::CMD_RELEASE:
            begin
                if (!hit)
                    status = ksa_pkg::ST_NOTFOUND;
                else
                begin
                    slot_taken[hit_slot] = 1'b0;
                    if (stack_depth < NUM_SLOTS)
                    begin
                        free_slots[stack_depth[3:0]] = hit_slot;
                        stack_depth                  = stack_depth + 1'b1;
                    end
                    slot   = hit_slot;
                    status = ksa_pkg::ST_RELEASED;
                end
            end
            default:
            begin
                // lookup, and the unused code behaves the same
                status = hit ? ksa_pkg::ST_BOUND : ksa_pkg::ST_NOTFOUND;
                slot   = hit ? hit_slot : 4'd0;
            end
        endcase

        r.status     = status;
        r.slot_index = slot;
        r.free_count = stack_depth;
        r.used_count = 5'(NUM_SLOTS) - stack_depth;
    endtask

    task automatic report_bad_word(input string what, input ksa_pkg::out_word_t want,
                                   input ksa_pkg::out_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected st=%0d slot=%0d free=%0d used=%0d, ",
                      "got st=%0d slot=%0d free=%0d used=%0d"},
                     $realtime, what, want.status, want.slot_index, want.free_count,
                     want.used_count, got.status, got.slot_index, got.free_count,
                     got.used_count);
    endtask

    always @(posedge clk)
    begin : watch
        ksa_pkg::out_word_t want;
        ksa_pkg::out_word_t next_want;
        if (!rst_n)
        begin
            clear_bindings();
            awaited_words.delete();
            pending = 0;
        end
        else
        begin
            // retire first: a result and a new word can share an edge
            if (done)
            begin
                if (awaited_words.size() == 0)
                    report_bad_word("unexpected result", '0, result);
                else
                begin
                    want = awaited_words.pop_front();
                    if (result.status !== want.status || result.slot_index !== want.slot_index ||
                        result.free_count !== want.free_count ||
                        result.used_count !== want.used_count)
                        report_bad_word("result mismatch", want, result);
                end
            end
            if (start && !busy)
            begin
                apply_request(request, next_want);
                awaited_words = {awaited_words, next_want};
            end
            pending = awaited_words.size();
        end
    end

endmodule

// File: test/tb_keyed_slot_allocator.sv
// Testbench top for the keyed slot allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_keyed_slot_allocator;

    localparam int         SLOTS        = ksa_pkg::NUM_SLOTS_DEF;
    localparam int         RANDOM_WORDS = 600;
    localparam int         POOL_SIZE    = 24;
    localparam int         LIMIT_CYCLES = 200000;
    localparam logic [1:0] CMD_SPARE    = 2'd3;   // undefined code, acts as lookup

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    ksa_pkg::in_word_t  request = '0;
    logic               busy;
    logic               done;
    ksa_pkg::out_word_t result;
    int                 chk_fails;
    int                 chk_outstanding;
    int                 cycle_count = 0;

    logic [31:0] id_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    keyed_slot_allocator #(.NUM_SLOTS(SLOTS)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    ksa_checker #(.NUM_SLOTS(SLOTS)) chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .request    (request),
        .result     (result),
        .fail_count (chk_fails),
        .outstanding(chk_outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Holds the word on the port until the edge that takes it.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] id);
        start              <= 1'b1;
        request.command    <= cmd;
        request.request_id <= id;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (chk_outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          burst_left;
        int          gap;
        int          alloc_pct;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] id;

        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme ids, hits and misses, every command, then the pool runs dry
        send_word(ksa_pkg::CMD_LOOKUP,  32'h0000_0005);
        send_word(ksa_pkg::CMD_ALLOC,   32'h0000_0000);
        send_word(ksa_pkg::CMD_ALLOC,   32'hFFFF_FFFF);
        send_word(ksa_pkg::CMD_ALLOC,   32'h0000_0000);
        send_word(ksa_pkg::CMD_LOOKUP,  32'hFFFF_FFFF);
        send_word(CMD_SPARE,            32'h0000_0000);
        send_word(ksa_pkg::CMD_RELEASE, 32'h0001_2345);
        send_word(ksa_pkg::CMD_RELEASE, 32'h0000_0000);
        send_word(CMD_SPARE,            32'h0000_0000);
        for (int i = 1; i < SLOTS; i++)
            send_word(ksa_pkg::CMD_ALLOC, 32'(i));
        send_word(ksa_pkg::CMD_ALLOC,   32'hAAAA_AAAA);
        wait_all_results();

        burst_left = 0;
        alloc_pct  = 25;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // swing between draining and filling so the stack hits both ends
            if (n % 50 == 0)
                alloc_pct = (n / 50) % 3 == 0 ? 25 : ((n / 50) % 3 == 1 ? 75 : 50);
            if (n == RANDOM_WORDS / 2)
                wait_all_results();
            if (burst_left == 0)
            begin
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
            end

            pick = $urandom_range(99);
            if (pick < alloc_pct)
                cmd = ksa_pkg::CMD_ALLOC;
            else if (pick < alloc_pct + (100 - alloc_pct) * 6 / 10)
                cmd = ksa_pkg::CMD_RELEASE;
            else if (pick < 93)
                cmd = ksa_pkg::CMD_LOOKUP;
            else
                cmd = CMD_SPARE;

            // mostly a small id set so that hits are common
            id = ($urandom_range(6) == 0) ? $urandom : id_pool[$urandom_range(POOL_SIZE - 1)];

            send_word(cmd, id);
            burst_left--;
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (chk_fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
